// ----- rtl/core/chac_pkg.sv -----
// Shared types, constants and the arctangent table of the heading align controller.
`default_nettype none
package chac_pkg;

  localparam int SAMPLES_PER_READING = 8;
  localparam int CORDIC_STEPS        = 16;
  localparam int SAMPLE_BITS         = 16;

  localparam int ATAN_ENTRIES = 24;
  localparam int ATAN_IDX_W   = 5;
  localparam int ATAN_W       = 23;
  localparam int CORDIC_N     = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
  localparam int STEP_W       = (CORDIC_N > 1) ? $clog2(CORDIC_N) : 1;

  localparam int SAMPLE_IN_W = 16;
  localparam bit SAMPLE_SEXT = (SAMPLE_BITS <= SAMPLE_IN_W);
  localparam int SAMPLE_KEEP = SAMPLE_SEXT ? SAMPLE_BITS : SAMPLE_IN_W;

  localparam int SUM_W = SAMPLE_BITS + $clog2(SAMPLES_PER_READING);
  localparam int CNT_W = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;
  localparam int CW    = SUM_W + 18;
  localparam int ZW    = 27;

  localparam int HALF_TURN = 2880;
  localparam int FULL_TURN = 5760;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_TICK   = 2'd2,
    OP_ABORT  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    STS_NO_SENSOR = 3'd0,
    STS_INVALID   = 3'd1,
    STS_ALIGNED   = 3'd2,
    STS_RIGHT     = 3'd3,
    STS_LEFT      = 3'd4,
    STS_TIMEOUT   = 3'd5,
    STS_ABORTED   = 3'd6
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAG_PRESENT = 3'd0,
    CFG_TOLERANCE   = 3'd1,
    CFG_TIMEOUT_MS  = 3'd2,
    CFG_SLOW_DRIVE  = 3'd3,
    CFG_FAST_DRIVE  = 3'd4,
    CFG_SLOW_BAND   = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    RES_NO_SENSOR,
    RES_TIMEOUT,
    RES_ABORT,
    RES_READING
  } res_sel_e;

  typedef struct packed {
    logic        mag_present;
    logic [11:0] tolerance;
    logic [15:0] timeout_ms;
    logic [7:0]  slow_drive;
    logic [7:0]  fast_drive;
    logic [11:0] slow_band;
  } chac_cfg_t;

  typedef struct packed {
    logic     acc_clear;
    logic     acc_add;
    logic     tick;
    logic     cordic_init;
    logic     cordic_step;
    logic     head_load;
    logic     res_load;
    res_sel_e res_sel;
  } chac_cmd_t;

  typedef struct packed {
    logic mag_present;
    logic timeout_zero;
    logic tick_expire;
    logic last_sample;
    logic reading_invalid;
    logic cordic_last;
    logic aligned;
  } chac_stat_t;

  // atan(2^-i) in 1/65536 degree, rounded.
  function automatic logic [ATAN_W-1:0] atan_val(input logic [ATAN_IDX_W-1:0] i);
    logic [ATAN_W-1:0] r;
    case (i)
      5'd0:    r = 23'd2949120;
      5'd1:    r = 23'd1740967;
      5'd2:    r = 23'd919879;
      5'd3:    r = 23'd466945;
      5'd4:    r = 23'd234379;
      5'd5:    r = 23'd117304;
      5'd6:    r = 23'd58666;
      5'd7:    r = 23'd29335;
      5'd8:    r = 23'd14668;
      5'd9:    r = 23'd7334;
      5'd10:   r = 23'd3667;
      5'd11:   r = 23'd1833;
      5'd12:   r = 23'd917;
      5'd13:   r = 23'd458;
      5'd14:   r = 23'd229;
      5'd15:   r = 23'd115;
      5'd16:   r = 23'd57;
      5'd17:   r = 23'd29;
      5'd18:   r = 23'd14;
      5'd19:   r = 23'd7;
      5'd20:   r = 23'd4;
      5'd21:   r = 23'd2;
      5'd22:   r = 23'd1;
      default: r = 23'd0;
    endcase
    return r;
  endfunction

  // Brings a raw sample port to accumulator width, signed at SAMPLE_BITS.
  function automatic logic signed [SUM_W-1:0] sample_ext(input logic [SAMPLE_IN_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    if (SAMPLE_SEXT) begin
      r = SUM_W'($signed(v[SAMPLE_KEEP-1:0]));
    end else begin
      r = SUM_W'(v);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/chac_cfg_regs.sv -----
// Configuration register file of the heading align controller.
`default_nettype none
module chac_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [chac_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [chac_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output chac_pkg::chac_cfg_t                 cfg_o
);
  import chac_pkg::*;

  chac_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MAG_PRESENT: cfg_d.mag_present = cfg_data_i[0];
        CFG_TOLERANCE:   cfg_d.tolerance   = cfg_data_i[11:0];
        CFG_TIMEOUT_MS:  cfg_d.timeout_ms  = cfg_data_i;
        CFG_SLOW_DRIVE:  cfg_d.slow_drive  = cfg_data_i[7:0];
        CFG_FAST_DRIVE:  cfg_d.fast_drive  = cfg_data_i[7:0];
        CFG_SLOW_BAND:   cfg_d.slow_band   = cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mag_present <= 1'b0;
      cfg_q.tolerance   <= 12'd32;
      cfg_q.timeout_ms  <= 16'd10000;
      cfg_q.slow_drive  <= 8'd70;
      cfg_q.fast_drive  <= 8'd95;
      cfg_q.slow_band   <= 12'd400;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/chac_datapath.sv -----
// Datapath: sample sums, tick counter, iterative CORDIC, heading error and result register.
`default_nettype none
module chac_datapath (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire chac_pkg::chac_cfg_t             cfg_i,
  input  wire chac_pkg::chac_cmd_t             cmd_i,
  output chac_pkg::chac_stat_t                 stat_o,
  input  wire logic [chac_pkg::SAMPLE_IN_W-1:0] mag_x_i,
  input  wire logic [chac_pkg::SAMPLE_IN_W-1:0] mag_y_i,
  output logic [2:0]                           status_o,
  output logic signed [8:0]                    left_drive_o,
  output logic signed [8:0]                    right_drive_o,
  output logic [12:0]                          heading_o,
  output logic signed [12:0]                   heading_error_o,
  output logic                                 run_done_o
);
  import chac_pkg::*;

  localparam logic signed [SUM_W-1:0] SUM_LIM = SUM_W'(SAMPLES_PER_READING);

  logic signed [SUM_W-1:0] sum_x_q, sum_x_d, sum_y_q, sum_y_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [15:0]             ticks_q, ticks_d, ticks_inc;
  logic [STEP_W-1:0]       step_q, step_d;
  logic                    inv_q, inv_d;

  logic signed [CW-1:0] x_q, x_d, y_q, y_d, x0, y0, dx, dy;
  logic signed [ZW-1:0] z_q, z_d, z_round, h_raw, h_wrap, atan_z;
  logic [12:0]          heading_q, heading_d;

  logic [2:0]        status_q, status_d;
  logic signed [8:0] left_q, left_d, right_q, right_d;
  logic [12:0]       hd_out_q, hd_out_d;
  logic signed [12:0] err_out_q, err_out_d;
  logic              done_q, done_d;

  logic signed [13:0] err_w, mag_w;
  logic [11:0]        mag;
  logic               aligned, slow;
  logic [7:0]         drive;
  logic signed [8:0]  drive_pos;

  // Control-side status.
  always_comb begin
    ticks_inc = (ticks_q == 16'hFFFF) ? ticks_q : ticks_q + 16'd1;
    stat_o.mag_present     = cfg_i.mag_present;
    stat_o.timeout_zero    = (cfg_i.timeout_ms == 16'd0);
    stat_o.tick_expire     = (ticks_inc >= cfg_i.timeout_ms);
    stat_o.last_sample     = (cnt_q == CNT_W'(SAMPLES_PER_READING - 1));
    stat_o.reading_invalid = (sum_x_q < SUM_LIM) && (sum_x_q > -SUM_LIM) &&
                             (sum_y_q < SUM_LIM) && (sum_y_q > -SUM_LIM);
    stat_o.cordic_last     = (step_q == STEP_W'(CORDIC_N - 1));
    stat_o.aligned         = aligned;
  end

  // Accumulator, tick counter and step counter.
  always_comb begin
    sum_x_d = sum_x_q;
    sum_y_d = sum_y_q;
    cnt_d   = cnt_q;
    ticks_d = ticks_q;
    step_d  = step_q;
    inv_d   = inv_q;
    if (cmd_i.acc_clear) begin
      sum_x_d = '0;
      sum_y_d = '0;
      cnt_d   = '0;
      ticks_d = '0;
    end
    if (cmd_i.acc_add) begin
      sum_x_d = sum_x_q + sample_ext(mag_x_i);
      sum_y_d = sum_y_q + sample_ext(mag_y_i);
      cnt_d   = cnt_q + CNT_W'(1);
    end
    if (cmd_i.tick) begin
      ticks_d = ticks_inc;
    end
    if (cmd_i.cordic_init) begin
      sum_x_d = '0;
      sum_y_d = '0;
      cnt_d   = '0;
      step_d  = '0;
      inv_d   = stat_o.reading_invalid;
    end
    if (cmd_i.cordic_step) begin
      step_d = step_q + STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_x_q <= '0;
      sum_y_q <= '0;
      cnt_q   <= '0;
      ticks_q <= '0;
      step_q  <= '0;
      inv_q   <= 1'b0;
    end else begin
      sum_x_q <= sum_x_d;
      sum_y_q <= sum_y_d;
      cnt_q   <= cnt_d;
      ticks_q <= ticks_d;
      step_q  <= step_d;
      inv_q   <= inv_d;
    end
  end

  // CORDIC vectoring, one rotation per cycle; >>> on a signed value floors.
  always_comb begin
    x0     = CW'(sum_x_q) <<< 16;
    y0     = CW'(sum_y_q) <<< 16;
    dx     = y_q >>> step_q;
    dy     = x_q >>> step_q;
    atan_z = ZW'(atan_val(ATAN_IDX_W'(step_q)));
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    if (cmd_i.cordic_init) begin
      if (sum_x_q < 0) begin
        x_d = -x0;
        y_d = -y0;
        z_d = ZW'(HALF_TURN * 4096);
      end else begin
        x_d = x0;
        y_d = y0;
        z_d = '0;
      end
    end else if (cmd_i.cordic_step) begin
      if (y_q > 0) begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + atan_z;
      end else begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - atan_z;
      end
    end
  end

  // Angle to 1/16 degree with rounding, folded into one turn.
  always_comb begin
    z_round = z_q + ZW'(2048);
    h_raw   = z_round >>> 12;
    if (h_raw < 0) begin
      h_wrap = h_raw + ZW'(FULL_TURN);
    end else if (h_raw >= ZW'(FULL_TURN)) begin
      h_wrap = h_raw - ZW'(FULL_TURN);
    end else begin
      h_wrap = h_raw;
    end
    heading_d = cmd_i.head_load ? h_wrap[12:0] : heading_q;
  end

  // Error toward north and the drive decision.
  always_comb begin
    if (heading_q <= 13'(HALF_TURN)) begin
      err_w = -$signed({1'b0, heading_q});
    end else begin
      err_w = 14'(FULL_TURN) - $signed({1'b0, heading_q});
    end
    mag_w     = (err_w < 0) ? -err_w : err_w;
    mag       = mag_w[11:0];
    aligned   = !inv_q && (mag <= cfg_i.tolerance);
    slow      = (mag < cfg_i.slow_band);
    drive     = slow ? cfg_i.slow_drive : cfg_i.fast_drive;
    drive_pos = $signed({1'b0, drive});
  end

  // Result register.
  always_comb begin
    status_d  = status_q;
    left_d    = left_q;
    right_d   = right_q;
    hd_out_d  = hd_out_q;
    err_out_d = err_out_q;
    done_d    = done_q;
    if (cmd_i.res_load) begin
      left_d    = '0;
      right_d   = '0;
      hd_out_d  = '0;
      err_out_d = '0;
      done_d    = 1'b1;
      unique case (cmd_i.res_sel)
        RES_NO_SENSOR: status_d = STS_NO_SENSOR;
        RES_TIMEOUT:   status_d = STS_TIMEOUT;
        RES_ABORT:     status_d = STS_ABORTED;
        RES_READING: begin
          if (inv_q) begin
            status_d = STS_INVALID;
            done_d   = 1'b0;
          end else begin
            hd_out_d  = heading_q;
            err_out_d = err_w[12:0];
            if (aligned) begin
              status_d = STS_ALIGNED;
            end else if (err_w > 0) begin
              status_d = STS_RIGHT;
              left_d   = drive_pos;
              right_d  = -drive_pos;
              done_d   = 1'b0;
            end else begin
              status_d = STS_LEFT;
              left_d   = -drive_pos;
              right_d  = drive_pos;
              done_d   = 1'b0;
            end
          end
        end
        default: status_d = STS_NO_SENSOR;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    x_q       <= x_d;
    y_q       <= y_d;
    z_q       <= z_d;
    heading_q <= heading_d;
    status_q  <= status_d;
    left_q    <= left_d;
    right_q   <= right_d;
    hd_out_q  <= hd_out_d;
    err_out_q <= err_out_d;
    done_q    <= done_d;
  end

  assign status_o        = status_q;
  assign left_drive_o    = left_q;
  assign right_drive_o   = right_q;
  assign heading_o       = hd_out_q;
  assign heading_error_o = err_out_q;
  assign run_done_o      = done_q;

endmodule
`default_nettype wire

// ----- rtl/core/chac_ctrl.sv -----
// Controller state machine: item decode, run state, CORDIC sequencing and output valid.
`default_nettype none
module chac_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [1:0]           op_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  input  wire chac_pkg::chac_stat_t stat_i,
  output chac_pkg::chac_cmd_t       cmd_o
);
  import chac_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_ITER,
    S_HEAD,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   running_q, running_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free, accept;

  // The result slot is free when empty or when its beat leaves this cycle.
  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE) && slot_free;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d   = state_q;
    running_d = running_q;
    cmd_o     = '0;
    cmd_o.res_sel = RES_READING;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (op_e'(op_i))
            OP_START: begin
              if (!stat_i.mag_present) begin
                cmd_o.res_load = 1'b1;
                cmd_o.res_sel  = RES_NO_SENSOR;
                running_d      = 1'b0;
              end else begin
                cmd_o.acc_clear = 1'b1;
                if (stat_i.timeout_zero) begin
                  cmd_o.res_load = 1'b1;
                  cmd_o.res_sel  = RES_TIMEOUT;
                  running_d      = 1'b0;
                end else begin
                  running_d = 1'b1;
                end
              end
            end
            OP_ABORT: begin
              if (running_q) begin
                cmd_o.res_load = 1'b1;
                cmd_o.res_sel  = RES_ABORT;
                running_d      = 1'b0;
              end
            end
            OP_TICK: begin
              if (running_q) begin
                cmd_o.tick = 1'b1;
                if (stat_i.tick_expire) begin
                  cmd_o.res_load = 1'b1;
                  cmd_o.res_sel  = RES_TIMEOUT;
                  running_d      = 1'b0;
                end
              end
            end
            OP_SAMPLE: begin
              if (running_q) begin
                cmd_o.acc_add = 1'b1;
                if (stat_i.last_sample) begin
                  state_d = S_PREP;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_PREP: begin
        cmd_o.cordic_init = 1'b1;
        state_d = stat_i.reading_invalid ? S_FINISH : S_ITER;
      end
      S_ITER: begin
        cmd_o.cordic_step = 1'b1;
        if (stat_i.cordic_last) begin
          state_d = S_HEAD;
        end
      end
      S_HEAD: begin
        cmd_o.head_load = 1'b1;
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RES_READING;
          if (stat_i.aligned) begin
            running_d = 1'b0;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cmd_o.res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      running_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      running_q   <= running_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/compass_heading_align_controller.sv -----
// Top level of the compass heading align controller.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o    op_i, mag_x_i, mag_y_i
//   out      output     out_valid_o / out_ready_i  status_o, left_drive_o, right_drive_o,
//                                                  heading_o, heading_error_o, run_done_o
//   cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// Start, tick, abort and non-final samples are handled without leaving S_IDLE.
// The sample that completes a reading holds off input while the controller passes
// through S_PREP, S_ITER, S_HEAD and S_FINISH, the rotations done by the single shared
// CORDIC rotation stage; an invalid reading goes from S_PREP straight to S_FINISH.
// Reset is immediate, with no clearing pass. An input beat is taken only while the
// result register is empty or draining, so a stalled output holds off new input.
`default_nettype none
module compass_heading_align_controller (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [1:0]                      op_i,
  input  wire logic [chac_pkg::SAMPLE_IN_W-1:0] mag_x_i,
  input  wire logic [chac_pkg::SAMPLE_IN_W-1:0] mag_y_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [2:0]                           status_o,
  output logic signed [8:0]                    left_drive_o,
  output logic signed [8:0]                    right_drive_o,
  output logic [12:0]                          heading_o,
  output logic signed [12:0]                   heading_error_o,
  output logic                                 run_done_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [chac_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [chac_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import chac_pkg::*;

  chac_cfg_t  cfg;
  chac_cmd_t  cmd;
  chac_stat_t stat;

  chac_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  chac_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  chac_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .mag_x_i         (mag_x_i),
    .mag_y_i         (mag_y_i),
    .status_o        (status_o),
    .left_drive_o    (left_drive_o),
    .right_drive_o   (right_drive_o),
    .heading_o       (heading_o),
    .heading_error_o (heading_error_o),
    .run_done_o      (run_done_o)
  );

endmodule
`default_nettype wire

// ----- tb/compass_heading_align_controller_tb.sv -----
// Self-checking testbench for the compass heading align controller.
module compass_heading_align_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import chac_pkg::*;

  localparam int ITEMS_TARGET  = 1400;
  localparam int SETTLE_CYCLES = 32;
  localparam int CYCLE_LIMIT   = 1_000_000;

  // Arctangent of 2^-i in 1/65536 degree.
  localparam longint ARCTAN_TABLE [0:23] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef struct packed {
    status_e            status;
    logic signed [8:0]  left_drive;
    logic signed [8:0]  right_drive;
    logic [12:0]        heading;
    logic signed [12:0] heading_error;
    logic               run_done;
  } align_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  op_e         op = OP_START;
  logic [15:0] mag_x = '0;
  logic [15:0] mag_y = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic signed [8:0]  left_drive;
  logic signed [8:0]  right_drive;
  logic [12:0]        heading;
  logic signed [12:0] heading_error;
  logic               run_done;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_idx_e    cfg_index = CFG_MAG_PRESENT;
  logic [15:0] cfg_data = '0;

  // Predictor copy of the registers and the run state.
  logic        pr_mag_present = 1'b0;
  logic [11:0] pr_tolerance = 12'd32;
  logic [15:0] pr_timeout = 16'd10000;
  logic [7:0]  pr_slow_drive = 8'd70;
  logic [7:0]  pr_fast_drive = 8'd95;
  logic [11:0] pr_slow_band = 12'd400;
  longint      acc_x = 0;
  longint      acc_y = 0;
  int          acc_count = 0;
  int          ticks_seen = 0;
  bit          run_open = 1'b0;

  align_result_t pending_results[$];

  int failures = 0;
  int beats_in = 0;
  int beats_out = 0;
  int cfg_writes = 0;
  int cycles = 0;
  int status_seen[8];
  int burst_left = 0;
  bit tx_gaps = 1'b1;
  int tick_pct = 10;
  int rx_hold = 0;
  int rx_mode = 0;
  int rx_mode_left = 0;

  compass_heading_align_controller i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .op_i            (op),
    .mag_x_i         (mag_x),
    .mag_y_i         (mag_y),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .status_o        (status),
    .left_drive_o    (left_drive),
    .right_drive_o   (right_drive),
    .heading_o       (heading),
    .heading_error_o (heading_error),
    .run_done_o      (run_done),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Vectoring CORDIC on the summed axes, heading in 1/16 degree over 0..5759.
  function automatic int heading_from_sums(longint sx, longint sy);
    longint x, y, z, dx, dy, h;
    x = sx * 65536;
    y = sy * 65536;
    z = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = longint'(HALF_TURN) * 4096;
    end
    for (int i = 0; i < CORDIC_N; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx;
        y -= dy;
        z += ARCTAN_TABLE[i];
      end else begin
        x -= dx;
        y += dy;
        z -= ARCTAN_TABLE[i];
      end
    end
    h = (z + 2048) >>> 12;
    while (h < 0) h += FULL_TURN;
    while (h >= FULL_TURN) h -= FULL_TURN;
    return int'(h);
  endfunction

  task automatic advance_alignment(op_e op_v, logic [15:0] x_v, logic [15:0] y_v);
    align_result_t r;
    longint sx, sy;
    int hd, err, mag;
    logic [7:0] d;
    bit produced;
    r = '0;
    produced = 1'b0;
    case (op_v)
      OP_START: begin
        if (!pr_mag_present) begin
          run_open = 1'b0;
          r.status = STS_NO_SENSOR;
          r.run_done = 1'b1;
          produced = 1'b1;
        end else begin
          acc_x = 0;
          acc_y = 0;
          acc_count = 0;
          ticks_seen = 0;
          if (pr_timeout == 0) begin
            run_open = 1'b0;
            r.status = STS_TIMEOUT;
            r.run_done = 1'b1;
            produced = 1'b1;
          end else begin
            run_open = 1'b1;
          end
        end
      end
      OP_ABORT: begin
        if (run_open) begin
          run_open = 1'b0;
          r.status = STS_ABORTED;
          r.run_done = 1'b1;
          produced = 1'b1;
        end
      end
      OP_TICK: begin
        if (run_open) begin
          if (ticks_seen < 16'hFFFF) ticks_seen++;
          if (ticks_seen >= pr_timeout) begin
            run_open = 1'b0;
            r.status = STS_TIMEOUT;
            r.run_done = 1'b1;
            produced = 1'b1;
          end
        end
      end
      default: begin
        if (run_open) begin
          acc_x += longint'($signed(x_v));
          acc_y += longint'($signed(y_v));
          acc_count++;
          if (acc_count >= SAMPLES_PER_READING) begin
            sx = acc_x;
            sy = acc_y;
            acc_x = 0;
            acc_y = 0;
            acc_count = 0;
            produced = 1'b1;
            if (sx < SAMPLES_PER_READING && sx > -SAMPLES_PER_READING &&
                sy < SAMPLES_PER_READING && sy > -SAMPLES_PER_READING) begin
              r.status = STS_INVALID;
            end else begin
              hd = heading_from_sums(sx, sy);
              err = (hd <= HALF_TURN) ? -hd : FULL_TURN - hd;
              mag = (err < 0) ? -err : err;
              r.heading = 13'(hd);
              r.heading_error = 13'(err);
              if (mag <= int'(pr_tolerance)) begin
                run_open = 1'b0;
                r.status = STS_ALIGNED;
                r.run_done = 1'b1;
              end else begin
                d = (mag < int'(pr_slow_band)) ? pr_slow_drive : pr_fast_drive;
                if (err > 0) begin
                  r.status = STS_RIGHT;
                  r.left_drive = $signed({1'b0, d});
                  r.right_drive = -$signed({1'b0, d});
                end else begin
                  r.status = STS_LEFT;
                  r.left_drive = -$signed({1'b0, d});
                  r.right_drive = $signed({1'b0, d});
                end
              end
            end
          end
        end
      end
    endcase
    if (produced) pending_results.push_back(r);
  endtask

  always @(posedge clk) begin
    align_result_t want;
    if (rst_n && out_valid && out_ready) begin
      beats_out++;
      if (pending_results.size() == 0) begin
        $error("unexpected result beat with status %0d", status);
        failures++;
      end else begin
        want = pending_results.pop_front();
        status_seen[want.status]++;
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          failures++;
        end
        if (left_drive !== want.left_drive) begin
          $error("left_drive: expected %0d, got %0d", want.left_drive, left_drive);
          failures++;
        end
        if (right_drive !== want.right_drive) begin
          $error("right_drive: expected %0d, got %0d", want.right_drive, right_drive);
          failures++;
        end
        if (heading !== want.heading) begin
          $error("heading: expected %0d, got %0d", want.heading, heading);
          failures++;
        end
        if (heading_error !== want.heading_error) begin
          $error("heading_error: expected %0d, got %0d", want.heading_error,
                 heading_error);
          failures++;
        end
        if (run_done !== want.run_done) begin
          $error("run_done: expected %0d, got %0d", want.run_done, run_done);
          failures++;
        end
      end
    end
  end

  // Result side: a forced hold-off when requested, otherwise a changing stall pattern.
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold--;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(20, 200);
      end
      rx_mode_left--;
      case (rx_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 1) == 1);
        2:       out_ready <= ($urandom_range(0, 9) != 0);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic send_item(op_e op_v, logic [15:0] x_v, logic [15:0] y_v);
    int gap;
    if (tx_gaps && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 3);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    op <= op_v;
    mag_x <= x_v;
    mag_y <= y_v;
    do @(posedge clk); while (!in_ready);
    advance_alignment(op_v, x_v, y_v);
    beats_in++;
  endtask

  // Stops offering beats, waits for every outstanding result, then lets the block settle.
  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(cfg_idx_e idx, int unsigned value);
    logic [15:0] v;
    v = value[15:0];
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MAG_PRESENT: pr_mag_present = v[0];
      CFG_TOLERANCE:   pr_tolerance = v[11:0];
      CFG_TIMEOUT_MS:  pr_timeout = v;
      CFG_SLOW_DRIVE:  pr_slow_drive = v[7:0];
      CFG_FAST_DRIVE:  pr_fast_drive = v[7:0];
      default:         pr_slow_band = v[11:0];
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_settings(int unsigned present, int unsigned tol, int unsigned tmo,
                                int unsigned slow, int unsigned fast, int unsigned band);
    quiesce();
    write_reg(CFG_MAG_PRESENT, present);
    write_reg(CFG_TOLERANCE, tol);
    write_reg(CFG_TIMEOUT_MS, tmo);
    write_reg(CFG_SLOW_DRIVE, slow);
    write_reg(CFG_FAST_DRIVE, fast);
    write_reg(CFG_SLOW_BAND, band);
  endtask

  function automatic logic [15:0] near(int center, int spread);
    int v;
    v = center + int'($urandom_range(0, 2 * spread)) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  function automatic logic [15:0] rail_value();
    case ($urandom_range(0, 3))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  // One reading's worth of samples, random, at the rails or around a chosen direction, ticks mixed in.
  task automatic send_reading(int kind);
    int bx, by, sp;
    logic [15:0] sx, sy;
    bx = 0;
    by = 0;
    sp = 1;
    case (kind)
      2: begin
        bx = int'($urandom_range(0, 65535)) - 32768;
        by = int'($urandom_range(0, 65535)) - 32768;
        sp = 300;
      end
      3: begin
        bx = $urandom_range(2000, 30000);
        by = int'($urandom_range(0, 2 * (bx / 30))) - bx / 30;
        sp = 20;
      end
      5: begin
        // Pointing roughly south, where the error wraps between the two extremes.
        bx = -int'($urandom_range(2000, 30000));
        by = int'($urandom_range(0, 200)) - 100;
        sp = 10;
      end
      default: ;
    endcase
    for (int n = 0; n < SAMPLES_PER_READING; n++) begin
      if ($urandom_range(0, 99) < tick_pct) send_item(OP_TICK, 16'($urandom), 16'($urandom));
      case (kind)
        0: begin
          sx = 16'($urandom);
          sy = 16'($urandom);
        end
        4: begin
          sx = rail_value();
          sy = rail_value();
        end
        default: begin
          sx = near(bx, sp);
          sy = near(by, sp);
        end
      endcase
      send_item(OP_SAMPLE, sx, sy);
    end
  endtask

  task automatic random_run();
    int ending;
    send_item(OP_START, 16'($urandom), 16'($urandom));
    repeat ($urandom_range(1, 5)) begin
      send_reading(($urandom_range(0, 2) == 0) ? 3 : $urandom_range(0, 5));
    end
    ending = $urandom_range(0, 9);
    if (ending < 3) begin
      send_item(OP_ABORT, 16'($urandom), 16'($urandom));
    end else if (ending == 3) begin
      // Broken reading: the next start must throw the partial sums away.
      repeat ($urandom_range(1, 7)) send_item(OP_SAMPLE, 16'($urandom), 16'($urandom));
    end else if (ending == 4) begin
      repeat ($urandom_range(1, 6)) begin
        send_item(op_e'($urandom_range(0, 3)), 16'($urandom), 16'($urandom));
      end
    end
  endtask

  task automatic test_directed();
    send_item(OP_START, 16'h0000, 16'h0000);
    send_item(OP_SAMPLE, 16'h7FFF, 16'h8000);
    send_item(OP_TICK, 16'hFFFF, 16'hFFFF);
    send_item(OP_ABORT, 16'h0000, 16'h0000);
    quiesce();
    write_reg(CFG_MAG_PRESENT, 1);
    send_item(OP_START, 16'h0000, 16'h0000);
    send_item(OP_ABORT, 16'h0000, 16'h0000);
    send_item(OP_START, 16'h0000, 16'h0000);
    send_item(OP_SAMPLE, 16'h8000, 16'h8000);
    send_item(OP_SAMPLE, 16'h8000, 16'h8000);
    send_item(OP_START, 16'h0000, 16'h0000);
    repeat (SAMPLES_PER_READING) send_item(OP_SAMPLE, 16'd20000, 16'd0);
    // Alternating rails cancel to a sum below the validity threshold.
    send_item(OP_START, 16'h0000, 16'h0000);
    for (int n = 0; n < SAMPLES_PER_READING; n++) begin
      send_item(OP_SAMPLE, n[0] ? 16'h8000 : 16'h7FFF, n[0] ? 16'h7FFF : 16'h8000);
    end
    quiesce();
    write_reg(CFG_TIMEOUT_MS, 0);
    send_item(OP_START, 16'h0000, 16'h0000);
    quiesce();
    write_reg(CFG_TIMEOUT_MS, 2);
    send_item(OP_START, 16'h0000, 16'h0000);
    send_item(OP_TICK, 16'h0000, 16'h0000);
    send_item(OP_TICK, 16'h0000, 16'h0000);
    send_item(OP_TICK, 16'h0000, 16'h0000);
  endtask

  task automatic test_register_extremes();
    apply_settings(1, 0, 1, 0, 255, 0);
    repeat (3) random_run();
    apply_settings(1, 2880, 65535, 255, 0, 2880);
    repeat (3) random_run();
    apply_settings(1, 0, 65535, 255, 0, 2880);
    repeat (3) random_run();
    apply_settings(0, 32, 10000, 70, 95, 400);
    repeat (2) random_run();
  endtask

  task automatic test_backpressure();
    apply_settings(1, 32, 10000, 70, 95, 400);
    tx_gaps = 1'b0;
    rx_hold = 400;
    repeat (15) begin
      send_item(OP_START, 16'h0000, 16'h0000);
      send_item(OP_ABORT, 16'h0000, 16'h0000);
    end
    quiesce();
    tx_gaps = 1'b1;
  endtask

  // Runs random settings and runs until the whole test has sent about ITEMS_TARGET beats.
  task automatic test_random();
    int unsigned tol, tmo, slow, fast, band;
    while (beats_in < ITEMS_TARGET) begin
      case ($urandom_range(0, 3))
        0:       tol = 0;
        1:       tol = 2880;
        2:       tol = $urandom_range(0, 64);
        default: tol = $urandom_range(0, 2880);
      endcase
      case ($urandom_range(0, 9))
        0:       tmo = 0;
        1, 2, 3: tmo = $urandom_range(1, 30);
        4:       tmo = 65535;
        default: tmo = $urandom_range(31, 65535);
      endcase
      slow = ($urandom_range(0, 3) == 0) ? 255 * $urandom_range(0, 1) : $urandom_range(0, 255);
      fast = ($urandom_range(0, 3) == 0) ? 255 * $urandom_range(0, 1) : $urandom_range(0, 255);
      case ($urandom_range(0, 3))
        0:       band = 0;
        1:       band = 2880;
        default: band = $urandom_range(0, 2880);
      endcase
      apply_settings(($urandom_range(0, 7) != 0), tol, tmo, slow, fast, band);
      tx_gaps = ($urandom_range(0, 3) != 0);
      tick_pct = $urandom_range(0, 25);
      repeat (6) random_run();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_register_extremes();
    test_backpressure();
    test_random();
    quiesce();
    $display("Run covered %0d input beats, %0d result beats and %0d register writes.",
             beats_in, beats_out, cfg_writes);
    $display(
      "%0d aligned, %0d right, %0d left, %0d invalid, %0d timeout, %0d aborted, %0d no sensor.",
      status_seen[STS_ALIGNED], status_seen[STS_RIGHT], status_seen[STS_LEFT],
      status_seen[STS_INVALID], status_seen[STS_TIMEOUT], status_seen[STS_ABORTED],
      status_seen[STS_NO_SENSOR]);
    if (failures == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/chac_pkg.sv
rtl/core/chac_cfg_regs.sv
rtl/core/chac_datapath.sv
rtl/core/chac_ctrl.sv
rtl/core/compass_heading_align_controller.sv
tb/compass_heading_align_controller_tb.sv
